// ----- hw/rtl/kwrf_pkg.sv -----
`default_nettype none

package kwrf_pkg;

  localparam int CharW   = 8;
  localparam int KeyW    = 64;
  localparam int KeyLenW = 4;
  localparam int CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] CFG_KEYWORD_BYTES  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_KEYWORD_LENGTH = CfgIdxW'(1);

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             out_char_valid;
    logic             out_last;
    logic             all_removed;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/keyword_removal_filter.sv -----
`default_nettype none

// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_ready_o    | text_char_i, text_last_i
// out     | output    | out_valid_o / out_ready_i  | out_char_o, out_char_valid_o,
//         |           |                            | out_last_o, all_removed_o
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A character that is not the last of its text needs no further state, so one transaction a
// cycle is sustained while the output queue has space; the compare across the cell row decides
// match or emit in the cycle the character is taken. After the last character the filter flushes
// each character left in the window, then checks that it is empty and pushes the end marker.
// Shortening the keyword between characters adds extra checks and dropped cells.
// Reset is asynchronous and active low; no clearing pass follows it.
// Input stalls while the two-entry output queue is full; configuration is always accepted.
module keyword_removal_filter #(
  parameter int MAX_KEY_LEN = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [kwrf_pkg::CharW-1:0]    text_char_i,
  input  wire                          text_last_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [kwrf_pkg::CharW-1:0]   out_char_o,
  output logic                         out_char_valid_o,
  output logic                         out_last_o,
  output logic                         all_removed_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [kwrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [kwrf_pkg::KeyW-1:0]     cfg_data_i
);
  import kwrf_pkg::*;

  localparam int FW = $clog2(MAX_KEY_LEN + 1);

  typedef enum logic [2:0] {
    S_RUN,
    S_LOOP,
    S_DROP,
    S_FLUSH,
    S_END
  } state_e;

  state_e           state_q, state_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [FW-1:0]    cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             hold_v_q, hold_v_d;
  logic [CharW-1:0] hold_c_q, hold_c_d;
  logic             any_q, any_d;
  logic [KeyW-1:0]  keyword_q;
  logic [FW-1:0]    key_len_q;
  logic [KeyLenW-1:0] len_wr;
  logic [FW-1:0]    len_clamped;

  logic             space_ok;
  logic             app;
  logic             shift;
  logic             emit;
  logic             iterate;
  logic             cur_last;
  logic [FW-1:0]    nf;
  logic             match;
  logic             push;
  result_t          push_data;
  result_t          out_data;
  logic             fifo_full;

  logic [MAX_KEY_LEN:0][CharW-1:0] win;
  logic [MAX_KEY_LEN-1:0]          eq;

  assign win[MAX_KEY_LEN] = '0;

  for (genvar i = 0; i < MAX_KEY_LEN; i++) begin : g_cell
    kwrf_cell u_cell (
      .clk_i       (clk_i),
      .text_char_i (text_char_i),
      .key_char_i  (keyword_q[CharW*i +: CharW]),
      .load_i      (app && (fill_q == FW'(i))),
      .shift_i     (shift),
      .next_eff_i  (win[i+1]),
      .eff_o       (win[i]),
      .eq_o        (eq[i])
    );
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      if ((FW'(i) < key_len_q) && !eq[i]) begin
        match = 1'b0;
      end
    end
  end

  // Configuration.
  assign cfg_ready_o = 1'b1;
  assign len_wr      = cfg_data_i[KeyLenW-1:0];

  always_comb begin
    if (len_wr == '0) begin
      len_clamped = FW'(1);
    end else if (len_wr > KeyLenW'(MAX_KEY_LEN)) begin
      len_clamped = FW'(MAX_KEY_LEN);
    end else begin
      len_clamped = FW'(len_wr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_q <= '0;
      key_len_q <= FW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEYWORD_BYTES:  keyword_q <= cfg_data_i;
        CFG_KEYWORD_LENGTH: key_len_q <= len_clamped;
        default: ;
      endcase
    end
  end

  assign space_ok   = !fifo_full;
  assign in_ready_o = (state_q == S_RUN) && space_ok;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    hold_v_d  = hold_v_q;
    hold_c_d  = hold_c_q;
    any_d     = any_q;
    app       = 1'b0;
    shift     = 1'b0;
    emit      = 1'b0;
    iterate   = 1'b0;
    push      = 1'b0;
    push_data = '0;
    cur_last  = last_q;
    nf        = fill_q;

    unique case (state_q)
      S_RUN: begin
        if (in_valid_i && space_ok) begin
          app      = 1'b1;
          nf       = fill_q + FW'(1);
          cur_last = text_last_i;
          last_d   = text_last_i;
          iterate  = 1'b1;
        end
      end
      S_LOOP: begin
        if (space_ok) begin
          iterate = 1'b1;
        end
      end
      S_DROP: begin
        if (space_ok) begin
          shift  = 1'b1;
          fill_d = fill_q - FW'(1);
          cnt_d  = cnt_q - FW'(1);
          if (cnt_q == FW'(1)) begin
            state_d = S_LOOP;
          end
        end
      end
      S_FLUSH: begin
        if (space_ok) begin
          if (fill_q == '0) begin
            state_d = S_END;
          end else begin
            emit   = 1'b1;
            shift  = 1'b1;
            fill_d = fill_q - FW'(1);
          end
        end
      end
      S_END: begin
        if (space_ok) begin
          push                     = 1'b1;
          push_data.out_char       = hold_v_q ? hold_c_q : '0;
          push_data.out_char_valid = hold_v_q;
          push_data.out_last       = 1'b1;
          push_data.all_removed    = !hold_v_q && !any_q;
          hold_v_d                 = 1'b0;
          any_d                    = 1'b0;
          last_d                   = 1'b0;
          state_d                  = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase

    if (iterate) begin
      if (nf >= key_len_q) begin
        if (match) begin
          if (nf == key_len_q) begin
            fill_d  = '0;
            state_d = cur_last ? S_FLUSH : S_RUN;
          end else begin
            fill_d  = nf;
            cnt_d   = key_len_q;
            state_d = S_DROP;
          end
        end else begin
          emit   = 1'b1;
          shift  = 1'b1;
          fill_d = nf - FW'(1);
          if ((nf - FW'(1)) >= key_len_q) begin
            state_d = S_LOOP;
          end else begin
            state_d = cur_last ? S_FLUSH : S_RUN;
          end
        end
      end else begin
        fill_d  = nf;
        state_d = cur_last ? S_FLUSH : S_RUN;
      end
    end

    // On the last character of a text the newest kept character waits in a holding
    // register until it is known whether it is the final result.
    if (emit) begin
      any_d = 1'b1;
      if (cur_last) begin
        if (hold_v_q) begin
          push                     = 1'b1;
          push_data.out_char       = hold_c_q;
          push_data.out_char_valid = 1'b1;
        end
        hold_c_d = win[0];
        hold_v_d = 1'b1;
      end else begin
        push                     = 1'b1;
        push_data.out_char       = win[0];
        push_data.out_char_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_RUN;
      fill_q   <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      hold_v_q <= 1'b0;
      any_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      hold_v_q <= hold_v_d;
      any_q    <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_c_q <= hold_c_d;
  end

  kwrf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data)
  );

  assign out_char_o       = out_data.out_char;
  assign out_char_valid_o = out_data.out_char_valid;
  assign out_last_o       = out_data.out_last;
  assign all_removed_o    = out_data.all_removed;

  a_run_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (fill_q < FW'(MAX_KEY_LEN)))
    else $error("Window holds too many characters between transactions.");

  a_hold_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> last_q)
    else $error("Held character outside the final character of a text.");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END) |-> (fill_q == '0))
    else $error("Window not empty at the end of a text.");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_END) && space_ok) |=> (!hold_v_q && !any_q && !last_q))
    else $error("Text state not cleared after the end marker.");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !push)
    else $error("Result pushed into a full output queue.");

endmodule

`default_nettype wire

// ----- hw/rtl/kwrf_cell.sv -----
`default_nettype none

module kwrf_cell (
  input  wire                     clk_i,
  input  wire [kwrf_pkg::CharW-1:0] text_char_i,
  input  wire [kwrf_pkg::CharW-1:0] key_char_i,
  input  wire                     load_i,
  input  wire                     shift_i,
  input  wire [kwrf_pkg::CharW-1:0] next_eff_i,
  output logic [kwrf_pkg::CharW-1:0] eff_o,
  output logic                    eq_o
);
  import kwrf_pkg::*;

  logic [CharW-1:0] char_q;
  logic [CharW-1:0] char_d;

  // The cell presents its contents with the incoming character already placed in it.
  assign eff_o  = load_i ? text_char_i : char_q;
  assign eq_o   = (eff_o == key_char_i);
  assign char_d = shift_i ? next_eff_i : eff_o;

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/kwrf_out_fifo.sv -----
`default_nettype none

module kwrf_out_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  wire kwrf_pkg::result_t  push_data_i,
  output logic                    full_o,
  output logic                    valid_o,
  input  wire                     ready_i,
  output kwrf_pkg::result_t       data_o
);
  import kwrf_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire
